### src/vmdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vmdf_pkg
// shared types and codes of the differential vote matrix filter
// ---------------------------------------------------------------------------
package vmdf_pkg;

  localparam int IDX_W  = 5;
  localparam int STR_W  = 10;
  localparam int CNT_W  = 6;
  localparam int ADDR_W = 3;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_VOTE   = 2'd1;
  localparam logic [1:0] OP_FILTER = 2'd2;

  localparam logic REG_OBJECT_COUNT = 1'b0;
  localparam logic REG_STAR_COUNT   = 1'b1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] object_index;
    logic [IDX_W-1:0] star_index;
  } item_t;

  typedef struct packed {
    logic             pair_found;
    logic [IDX_W-1:0] matched_object;
    logic [IDX_W-1:0] matched_star;
    logic [STR_W-1:0] strength;
    logic             last_pair;
  } result_t;

endpackage
`default_nettype wire

### src/vote_matrix_differential_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vote_matrix_differential_filter
// object-by-star vote matrix with differential filtering of matched pairs
// ---------------------------------------------------------------------------
// The vote counters live in one synchronous memory with registered read
// data. A vote item in the rows and columns in use is a read-modify-write
// of one cell (read, write back, then back to idle before the next item);
// a vote outside them and the unused opcode leave the next item free on the
// following cycle. A clear item sweeps every cell of the memory, one a
// cycle, and the same sweep runs after reset, during which no item is
// taken. A filter item takes two passes over the rows and columns in use,
// each with a read and a write step per cell, and the second may also wait
// on the result side. The first pass records, per row and per column, the
// largest and second largest vote and where the largest sits; the second
// pass forms for each cell the largest competing vote, writes the kept
// value back and emits kept pairs. One kept pair is held back so the final
// one can carry last_pair; with no kept pair a single empty result closes
// the run. Items are taken one at a time; a finished result may wait in the
// output register while the next item is accepted.
module vote_matrix_differential_filter #(
  parameter int MAX_OBJECTS = 32,
  parameter int MAX_STARS   = 32,
  parameter int VOTE_BITS   = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // item channel
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire vmdf_pkg::item_t                   item,
  // result channel
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output vmdf_pkg::result_t                      result,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [vmdf_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  localparam int CELLS = MAX_OBJECTS * MAX_STARS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_OBJECTS);
  localparam int CW    = $clog2(MAX_STARS);
  localparam int RCW   = $clog2(MAX_OBJECTS + 1);
  localparam int CCW   = $clog2(MAX_STARS + 1);
  localparam int VB    = VOTE_BITS;
  localparam logic [VB-1:0] VOTE_MAX = {VB{1'b1}};

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CLEAR    = 4'd1;
  localparam logic [3:0] ST_VOTE_RD  = 4'd2;
  localparam logic [3:0] ST_VOTE_WR  = 4'd3;
  localparam logic [3:0] ST_SCAN_RD  = 4'd4;
  localparam logic [3:0] ST_SCAN_WR  = 4'd5;
  localparam logic [3:0] ST_APPLY_RD = 4'd6;
  localparam logic [3:0] ST_APPLY_WR = 4'd7;
  localparam logic [3:0] ST_FLUSH    = 4'd8;

  // configuration registers
  logic [vmdf_pkg::CNT_W-1:0] object_count;
  logic [vmdf_pkg::CNT_W-1:0] star_count;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_count <= vmdf_pkg::CNT_W'(32);
      star_count   <= vmdf_pkg::CNT_W'(32);
    end else if (cfg_write) begin
      case (paddr[2])
        vmdf_pkg::REG_OBJECT_COUNT: object_count <= pwdata[vmdf_pkg::CNT_W-1:0];
        vmdf_pkg::REG_STAR_COUNT:   star_count   <= pwdata[vmdf_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      vmdf_pkg::REG_OBJECT_COUNT: prdata = 32'(object_count);
      vmdf_pkg::REG_STAR_COUNT:   prdata = 32'(star_count);
      default:                    prdata = 32'd0;
    endcase
  end

  // rows and columns in use, zero acts as one, clipped to the matrix size
  logic [RCW-1:0] rows_use;
  logic [CCW-1:0] cols_use;

  always_comb begin
    if (object_count == '0) begin
      rows_use = RCW'(1);
    end else if (32'(object_count) > MAX_OBJECTS) begin
      rows_use = RCW'(MAX_OBJECTS);
    end else begin
      rows_use = RCW'(object_count);
    end
    if (star_count == '0) begin
      cols_use = CCW'(1);
    end else if (32'(star_count) > MAX_STARS) begin
      cols_use = CCW'(MAX_STARS);
    end else begin
      cols_use = CCW'(star_count);
    end
  end

  // control state
  logic [3:0]        state;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     vote_addr;
  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic              held_valid;
  vmdf_pkg::result_t held;

  // row statistics accumulated along the current row in the first pass
  logic [VB-1:0] acc_top1;
  logic [VB-1:0] acc_top2;
  logic [CW-1:0] acc_idx;

  logic item_take;
  logic last_col;
  logic last_row;
  logic out_free;

  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign last_col   = (32'(col) == 32'(cols_use) - 1);
  assign last_row   = (32'(row) == 32'(rows_use) - 1);
  assign out_free   = !result_valid || !result_stall;

  // memories
  logic          cell_we;
  logic [AW-1:0] cell_waddr;
  logic [VB-1:0] cell_wdata;
  logic [AW-1:0] cell_raddr;
  logic [VB-1:0] cell_rd;
  logic [AW-1:0] scan_addr;

  logic                 row_we;
  logic [2*VB+CW-1:0]   row_wdata;
  logic [2*VB+CW-1:0]   row_rd;
  logic                 col_we;
  logic [2*VB+RW-1:0]   col_wdata;
  logic [2*VB+RW-1:0]   col_rd;

  assign scan_addr = AW'(32'(row) * MAX_STARS + 32'(col));

  vmdf_ram #(.WIDTH(VB), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rd)
  );

  vmdf_ram #(.WIDTH(2*VB+CW), .DEPTH(MAX_OBJECTS)) u_row_stats (
    .clk   (clk),
    .we    (row_we),
    .waddr (row),
    .wdata (row_wdata),
    .raddr (row),
    .rdata (row_rd)
  );

  vmdf_ram #(.WIDTH(2*VB+RW), .DEPTH(MAX_STARS)) u_col_stats (
    .clk   (clk),
    .we    (col_we),
    .waddr (col),
    .wdata (col_wdata),
    .raddr (col),
    .rdata (col_rd)
  );

  // first pass: fold the cell into row and column top-two statistics
  logic [VB-1:0] r1_cur, r2_cur, c1_cur, c2_cur;
  logic [CW-1:0] ri_cur;
  logic [RW-1:0] ci_cur;
  logic [VB-1:0] r1_new, r2_new, c1_new, c2_new;
  logic [CW-1:0] ri_new;
  logic [RW-1:0] ci_new;

  always_comb begin
    if (col == '0) begin
      r1_cur = '0;
      r2_cur = '0;
      ri_cur = '0;
    end else begin
      r1_cur = acc_top1;
      r2_cur = acc_top2;
      ri_cur = acc_idx;
    end
    if (row == '0) begin
      c1_cur = '0;
      c2_cur = '0;
      ci_cur = '0;
    end else begin
      {c1_cur, ci_cur, c2_cur} = col_rd;
    end
    r1_new = r1_cur;
    r2_new = r2_cur;
    ri_new = ri_cur;
    if (cell_rd > r1_cur) begin
      r1_new = cell_rd;
      r2_new = r1_cur;
      ri_new = col;
    end else if (cell_rd > r2_cur) begin
      r2_new = cell_rd;
    end
    c1_new = c1_cur;
    c2_new = c2_cur;
    ci_new = ci_cur;
    if (cell_rd > c1_cur) begin
      c1_new = cell_rd;
      c2_new = c1_cur;
      ci_new = row;
    end else if (cell_rd > c2_cur) begin
      c2_new = cell_rd;
    end
  end

  // second pass: competing maximum and kept value
  logic [VB-1:0]     rs1, rs2, cs1, cs2;
  logic [CW-1:0]     rsi;
  logic [RW-1:0]     csi;
  logic [VB-1:0]     row_base, col_base, base;
  logic [VB:0]       twice_base;
  logic [VB-1:0]     kept;
  logic              keep;
  logic              apply_go;
  logic [VB+9:0]     kept_ext;
  vmdf_pkg::result_t pair;
  vmdf_pkg::result_t empty_res;
  vmdf_pkg::result_t held_last;

  always_comb begin
    {rs1, rsi, rs2} = row_rd;
    {cs1, csi, cs2} = col_rd;
    row_base   = (rsi == col) ? rs2 : rs1;
    col_base   = (csi == row) ? cs2 : cs1;
    base       = (row_base > col_base) ? row_base : col_base;
    twice_base = {base, 1'b0};
    kept       = ({1'b0, cell_rd} > twice_base) ? (cell_rd - base) : '0;
    keep       = (kept != '0);
    kept_ext   = {10'd0, kept};
    // a push is needed only when an earlier pair is held
    apply_go   = !(keep && held_valid && !out_free);

    pair.pair_found     = 1'b1;
    pair.matched_object = vmdf_pkg::IDX_W'(row);
    pair.matched_star   = vmdf_pkg::IDX_W'(col);
    pair.strength       = kept_ext[vmdf_pkg::STR_W-1:0];
    pair.last_pair      = 1'b0;

    empty_res           = '0;
    empty_res.last_pair = 1'b1;

    // the held pair closing the run
    held_last           = held;
    held_last.last_pair = 1'b1;
  end

  // memory port control
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = scan_addr;
    cell_wdata = '0;
    cell_raddr = scan_addr;
    row_we     = 1'b0;
    row_wdata  = {r1_new, ri_new, r2_new};
    col_we     = 1'b0;
    col_wdata  = {c1_new, ci_new, c2_new};
    case (state)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr;
      end
      ST_VOTE_RD: begin
        cell_raddr = vote_addr;
      end
      ST_VOTE_WR: begin
        cell_raddr = vote_addr;
        cell_waddr = vote_addr;
        cell_we    = 1'b1;
        cell_wdata = (cell_rd == VOTE_MAX) ? cell_rd : cell_rd + VB'(1);
      end
      ST_SCAN_WR: begin
        col_we = 1'b1;
        row_we = last_col;
      end
      ST_APPLY_WR: begin
        cell_we    = apply_go;
        cell_wdata = kept;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      row        <= '0;
      col        <= '0;
      held_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_take) begin
            case (item.opcode)
              vmdf_pkg::OP_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              vmdf_pkg::OP_VOTE: begin
                // votes outside the rows or columns in use are dropped
                if (32'(item.object_index) < 32'(rows_use) &&
                    32'(item.star_index) < 32'(cols_use)) begin
                  state <= ST_VOTE_RD;
                end
              end
              vmdf_pkg::OP_FILTER: begin
                row   <= '0;
                col   <= '0;
                state <= ST_SCAN_RD;
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == CELLS - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_VOTE_RD:  state <= ST_VOTE_WR;
        ST_VOTE_WR:  state <= ST_IDLE;
        ST_SCAN_RD:  state <= ST_SCAN_WR;
        ST_SCAN_WR: begin
          if (last_col) begin
            col <= '0;
            if (last_row) begin
              row   <= '0;
              state <= ST_APPLY_RD;
            end else begin
              row   <= row + RW'(1);
              state <= ST_SCAN_RD;
            end
          end else begin
            col   <= col + CW'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_APPLY_RD: state <= ST_APPLY_WR;
        ST_APPLY_WR: begin
          if (apply_go) begin
            if (keep) begin
              held_valid <= 1'b1;
            end
            if (last_col) begin
              col <= '0;
              if (last_row) begin
                row   <= '0;
                state <= ST_FLUSH;
              end else begin
                row   <= row + RW'(1);
                state <= ST_APPLY_RD;
              end
            end else begin
              col   <= col + CW'(1);
              state <= ST_APPLY_RD;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            held_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_take) begin
      vote_addr <= AW'(32'(item.object_index) * MAX_STARS + 32'(item.star_index));
    end
    if (state == ST_SCAN_WR) begin
      acc_top1 <= r1_new;
      acc_top2 <= r2_new;
      acc_idx  <= ri_new;
    end
    if (state == ST_APPLY_WR && apply_go && keep) begin
      held <= pair;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_APPLY_WR && apply_go && keep && held_valid) begin
      // a newer pair exists, so the held one is not the last
      result_valid <= 1'b1;
      result       <= held;
    end else if (state == ST_FLUSH && out_free) begin
      result_valid <= 1'b1;
      result       <= held_valid ? held_last : empty_res;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !held_valid)
    else $error("pair still held after a filter run");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.pair_found |-> result.last_pair)
    else $error("empty result without last marker");

  a_filter_starts_scan: assert property (@(posedge clk) disable iff (rst)
    item_take && item.opcode == vmdf_pkg::OP_FILTER |=> state == ST_SCAN_RD)
    else $error("filter item did not start the scan pass");

  a_scan_row_in_use: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN_WR || state == ST_APPLY_WR |->
      32'(row) < 32'(rows_use) && 32'(col) < 32'(cols_use))
    else $error("filter pass outside the rows or columns in use");
`endif

endmodule
`default_nettype wire

### src/vmdf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vmdf_ram
// single port write, single port read memory with registered read data
// ---------------------------------------------------------------------------
module vmdf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
